@@ rtl/core/sata_command_descriptor_builder_core_assert.svh @@
// Assertion helpers for the descriptor builder core.
`ifndef SATA_COMMAND_DESCRIPTOR_BUILDER_CORE_ASSERT_SVH
`define SATA_COMMAND_DESCRIPTOR_BUILDER_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SDB_ASSERT_NOW(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("sdb assertion failed");

// Next-cycle implication, checked out of reset.
`define SDB_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("sdb assertion failed");

`endif

@@ rtl/core/sdb_pkg.sv @@
`default_nettype none
package sdb_pkg;

   localparam int unsigned MAX_ENTRIES       = 8;
   localparam int unsigned SECTORS_PER_ENTRY = 16;
   localparam int unsigned SLOT_COUNT        = 32;
   localparam int unsigned SECTOR_SHIFT      = 9;

   localparam int unsigned SLOT_W   = 5;
   localparam int unsigned ENTRY_W  = 4;
   localparam int unsigned SEC_W    = $clog2(SECTORS_PER_ENTRY);
   localparam int unsigned BYTES_W  = 13;
   localparam int unsigned ENTCALC_W = 17 - SEC_W;

   localparam logic [BYTES_W-1:0] FULL_BYTES_M1 =
      BYTES_W'((SECTORS_PER_ENTRY << SECTOR_SHIFT) - 1);
   localparam logic [63:0] REGION_STRIDE = 64'(SECTORS_PER_ENTRY << SECTOR_SHIFT);

   localparam logic [7:0] ATA_READ_DMA_EXT  = 8'h25;
   localparam logic [7:0] ATA_WRITE_DMA_EXT = 8'h35;

   typedef enum logic [1:0] {
      KIND_COMMAND = 2'd0,
      KIND_REGION  = 2'd1,
      KIND_ERROR   = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ERR_NONE      = 2'd0,
      ERR_NO_SLOT   = 2'd1,
      ERR_BAD_COUNT = 2'd2
   } error_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COMMAND,
      ST_REGION
   } back_state_type;

   typedef struct packed {
      logic              is_error;
      error_type         err;
      logic [SLOT_W-1:0] slot;
      logic              wr;
      logic [ENTRY_W-1:0] entries;
      logic [47:0]       lba;
      logic [15:0]       count;
      logic [63:0]       addr;
      logic [SEC_W-1:0]  last_m1;
   } job_type;

endpackage
`default_nettype wire

@@ rtl/core/sdb_front.sv @@
`default_nettype none
module sdb_front (
   input  wire logic                  req_opcode,
   input  wire logic [47:0]           req_lba,
   input  wire logic [15:0]           req_sector_count,
   input  wire logic [63:0]           req_buffer_address,
   input  wire logic [31:0]           req_busy_slots,
   output sdb_pkg::job_type           job
);

   logic [sdb_pkg::SLOT_COUNT-1:0]    free_slots;
   logic [sdb_pkg::SLOT_W-1:0]        slot;
   logic                              no_slot;
   logic [15:0]                       count_m1;
   logic [sdb_pkg::ENTCALC_W-1:0]     entries_full;
   logic                              bad_count;

   always_comb begin
      free_slots = ~req_busy_slots[sdb_pkg::SLOT_COUNT-1:0];
      slot = '0;
      for (int i = sdb_pkg::SLOT_COUNT - 1; i >= 0; i--) begin
         if (free_slots[i]) begin
            slot = sdb_pkg::SLOT_W'(i);
         end
      end
      no_slot = ~|free_slots;
   end

   assign count_m1     = req_sector_count - 16'd1;
   assign entries_full = sdb_pkg::ENTCALC_W'(count_m1 >> sdb_pkg::SEC_W)
                         + sdb_pkg::ENTCALC_W'(1);
   assign bad_count    = (req_sector_count == 16'd0)
                         || (entries_full > sdb_pkg::ENTCALC_W'(sdb_pkg::MAX_ENTRIES));

   always_comb begin
      job          = '0;
      job.slot     = slot;
      job.wr       = req_opcode;
      job.entries  = entries_full[sdb_pkg::ENTRY_W-1:0];
      job.lba      = req_lba;
      job.count    = req_sector_count;
      job.addr     = req_buffer_address;
      job.last_m1  = count_m1[sdb_pkg::SEC_W-1:0];
      job.err      = sdb_pkg::ERR_NONE;
      job.is_error = 1'b0;
      if (no_slot) begin
         job.is_error = 1'b1;
         job.err      = sdb_pkg::ERR_NO_SLOT;
      end else if (bad_count) begin
         job.is_error = 1'b1;
         job.err      = sdb_pkg::ERR_BAD_COUNT;
      end
   end

endmodule
`default_nettype wire

@@ rtl/core/sdb_queue.sv @@
`default_nettype none
module sdb_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire sdb_pkg::job_type  push_data,
   output logic                   full,
   input  wire logic              pop,
   output logic                   pop_valid,
   output sdb_pkg::job_type       pop_data
);

   sdb_pkg::job_type  mem_ff [2];
   logic              wr_ptr_ff;
   logic              wr_ptr_in;
   logic              rd_ptr_ff;
   logic              rd_ptr_in;
   logic [1:0]        count_ff;
   logic [1:0]        count_in;
   logic              do_push;
   logic              do_pop;

   assign full      = (count_ff == 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop_data  = mem_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = do_push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

@@ rtl/core/sdb_back.sv @@
`default_nettype none
module sdb_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          q_valid,
   input  wire sdb_pkg::job_type              q_data,
   output logic                               q_pop,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [1:0]                         rsp_item_kind,
   output logic [1:0]                         rsp_error_code,
   output logic [sdb_pkg::SLOT_W-1:0]         rsp_slot,
   output logic                               rsp_write_dir,
   output logic [sdb_pkg::ENTRY_W-1:0]        rsp_entry_count,
   output logic [7:0]                         rsp_ata_command,
   output logic [47:0]                        rsp_cmd_lba,
   output logic [15:0]                        rsp_cmd_sectors,
   output logic [63:0]                        rsp_region_address,
   output logic [sdb_pkg::BYTES_W-1:0]        rsp_region_bytes_m1,
   output logic                               rsp_irq_on_done,
   output logic                               rsp_last
);

   sdb_pkg::back_state_type            state_ff, state_in;
   sdb_pkg::job_type                   job_ff, job_in;
   logic [63:0]                        addr_ff, addr_in;
   logic [sdb_pkg::ENTRY_W-1:0]        left_ff, left_in;
   logic                               valid_ff, valid_in;
   logic                               out_free;
   logic                               emit;
   logic                               finish;

   logic [1:0]                         kind_ff, kind_in;
   logic [1:0]                         err_ff, err_in;
   logic [sdb_pkg::SLOT_W-1:0]         slot_ff, slot_in;
   logic                               wdir_ff, wdir_in;
   logic [sdb_pkg::ENTRY_W-1:0]        ent_ff, ent_in;
   logic [7:0]                         ata_ff, ata_in;
   logic [47:0]                        lba_ff, lba_in;
   logic [15:0]                        sect_ff, sect_in;
   logic [63:0]                        raddr_ff, raddr_in;
   logic [sdb_pkg::BYTES_W-1:0]        bytes_ff, bytes_in;
   logic                               irq_ff, irq_in;
   logic                               last_ff, last_in;

   assign out_free = !valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      job_in   = job_ff;
      addr_in  = addr_ff;
      left_in  = left_ff;
      q_pop    = 1'b0;
      emit     = 1'b0;
      finish   = 1'b0;
      kind_in  = sdb_pkg::KIND_COMMAND;
      err_in   = sdb_pkg::ERR_NONE;
      slot_in  = '0;
      wdir_in  = 1'b0;
      ent_in   = '0;
      ata_in   = '0;
      lba_in   = '0;
      sect_in  = '0;
      raddr_in = '0;
      bytes_in = '0;
      irq_in   = 1'b0;
      last_in  = 1'b0;
      unique case (state_ff)
         sdb_pkg::ST_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               job_in   = q_data;
               state_in = sdb_pkg::ST_COMMAND;
            end
         end
         sdb_pkg::ST_COMMAND: begin
            if (out_free) begin
               emit = 1'b1;
               if (job_ff.is_error) begin
                  kind_in = sdb_pkg::KIND_ERROR;
                  err_in  = job_ff.err;
                  last_in = 1'b1;
                  finish  = 1'b1;
               end else begin
                  kind_in  = sdb_pkg::KIND_COMMAND;
                  slot_in  = job_ff.slot;
                  wdir_in  = job_ff.wr;
                  ent_in   = job_ff.entries;
                  ata_in   = job_ff.wr ? sdb_pkg::ATA_WRITE_DMA_EXT
                                       : sdb_pkg::ATA_READ_DMA_EXT;
                  lba_in   = job_ff.lba;
                  sect_in  = job_ff.count;
                  addr_in  = job_ff.addr;
                  left_in  = job_ff.entries;
                  state_in = sdb_pkg::ST_REGION;
               end
            end
         end
         sdb_pkg::ST_REGION: begin
            if (out_free) begin
               emit     = 1'b1;
               kind_in  = sdb_pkg::KIND_REGION;
               wdir_in  = job_ff.wr;
               irq_in   = job_ff.wr;
               raddr_in = addr_ff;
               addr_in  = addr_ff + sdb_pkg::REGION_STRIDE;
               left_in  = left_ff - sdb_pkg::ENTRY_W'(1);
               if (left_ff == sdb_pkg::ENTRY_W'(1)) begin
                  bytes_in = sdb_pkg::BYTES_W'({job_ff.last_m1,
                                                {sdb_pkg::SECTOR_SHIFT{1'b1}}});
                  last_in  = 1'b1;
                  finish   = 1'b1;
               end else begin
                  bytes_in = sdb_pkg::FULL_BYTES_M1;
               end
            end
         end
         default: begin
            state_in = sdb_pkg::ST_IDLE;
         end
      endcase
      if (finish) begin
         if (q_valid) begin
            q_pop    = 1'b1;
            job_in   = q_data;
            state_in = sdb_pkg::ST_COMMAND;
         end else begin
            state_in = sdb_pkg::ST_IDLE;
         end
      end
      valid_in = out_free ? emit : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sdb_pkg::ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff  <= job_in;
      addr_ff <= addr_in;
      left_ff <= left_in;
      if (emit) begin
         kind_ff  <= kind_in;
         err_ff   <= err_in;
         slot_ff  <= slot_in;
         wdir_ff  <= wdir_in;
         ent_ff   <= ent_in;
         ata_ff   <= ata_in;
         lba_ff   <= lba_in;
         sect_ff  <= sect_in;
         raddr_ff <= raddr_in;
         bytes_ff <= bytes_in;
         irq_ff   <= irq_in;
         last_ff  <= last_in;
      end
   end

   assign rsp_valid           = valid_ff;
   assign rsp_item_kind       = kind_ff;
   assign rsp_error_code      = err_ff;
   assign rsp_slot            = slot_ff;
   assign rsp_write_dir       = wdir_ff;
   assign rsp_entry_count     = ent_ff;
   assign rsp_ata_command     = ata_ff;
   assign rsp_cmd_lba         = lba_ff;
   assign rsp_cmd_sectors     = sect_ff;
   assign rsp_region_address  = raddr_ff;
   assign rsp_region_bytes_m1 = bytes_ff;
   assign rsp_irq_on_done     = irq_ff;
   assign rsp_last            = last_ff;

endmodule
`default_nettype wire

@@ rtl/core/sata_command_descriptor_builder_core.sv @@
`default_nettype none
// Builds AHCI-style command descriptors: each accepted request yields one command
// beat (lowest free slot, direction, region count, ATA opcode, LBA, sector count)
// followed by one region beat per 16 sectors, 8 KiB each but the last may be
// shorter, or a single error beat when no slot is free or the count is zero or
// needs more than eight regions. The result side sends one beat per cycle unless
// rsp_stall holds it, so a request yields entries + 1 beats (2 to 9), or one for
// an error; the output register of the back end sets that rate. A two-entry queue
// between the front end and the back end lets two more requests be taken while
// one is being sent. There is no configuration and nothing to clear after reset.
`include "sata_command_descriptor_builder_core_assert.svh"
module sata_command_descriptor_builder_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic                          req_opcode,
   input  wire logic [47:0]                   req_lba,
   input  wire logic [15:0]                   req_sector_count,
   input  wire logic [63:0]                   req_buffer_address,
   input  wire logic [31:0]                   req_busy_slots,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic [1:0]                         rsp_item_kind,
   output logic [1:0]                         rsp_error_code,
   output logic [sdb_pkg::SLOT_W-1:0]         rsp_slot,
   output logic                               rsp_write_dir,
   output logic [sdb_pkg::ENTRY_W-1:0]        rsp_entry_count,
   output logic [7:0]                         rsp_ata_command,
   output logic [47:0]                        rsp_cmd_lba,
   output logic [15:0]                        rsp_cmd_sectors,
   output logic [63:0]                        rsp_region_address,
   output logic [sdb_pkg::BYTES_W-1:0]        rsp_region_bytes_m1,
   output logic                               rsp_irq_on_done,
   output logic                               rsp_last
);

   sdb_pkg::job_type  front_job;
   sdb_pkg::job_type  q_data;
   logic              q_full;
   logic              q_valid;
   logic              q_pop;

   sdb_front u_front (
      .req_opcode         (req_opcode),
      .req_lba            (req_lba),
      .req_sector_count   (req_sector_count),
      .req_buffer_address (req_buffer_address),
      .req_busy_slots     (req_busy_slots),
      .job                (front_job)
   );

   sdb_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_valid),
      .push_data (front_job),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_data  (q_data)
   );

   assign req_stall = q_full;

   sdb_back u_back (
      .clock               (clock),
      .reset               (reset),
      .q_valid             (q_valid),
      .q_data              (q_data),
      .q_pop               (q_pop),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_item_kind       (rsp_item_kind),
      .rsp_error_code      (rsp_error_code),
      .rsp_slot            (rsp_slot),
      .rsp_write_dir       (rsp_write_dir),
      .rsp_entry_count     (rsp_entry_count),
      .rsp_ata_command     (rsp_ata_command),
      .rsp_cmd_lba         (rsp_cmd_lba),
      .rsp_cmd_sectors     (rsp_cmd_sectors),
      .rsp_region_address  (rsp_region_address),
      .rsp_region_bytes_m1 (rsp_region_bytes_m1),
      .rsp_irq_on_done     (rsp_irq_on_done),
      .rsp_last            (rsp_last)
   );

   `SDB_ASSERT_NOW(a_error_is_last, clock, reset,
      rsp_valid && (rsp_item_kind == sdb_pkg::KIND_ERROR), rsp_last)
   `SDB_ASSERT_NOW(a_region_irq_dir, clock, reset,
      rsp_valid && (rsp_item_kind == sdb_pkg::KIND_REGION),
      rsp_irq_on_done == rsp_write_dir)
   `SDB_ASSERT_NOW(a_command_entries, clock, reset,
      rsp_valid && (rsp_item_kind == sdb_pkg::KIND_COMMAND),
      (rsp_entry_count != '0) && !rsp_last &&
      (rsp_entry_count <= sdb_pkg::ENTRY_W'(sdb_pkg::MAX_ENTRIES)))
   `SDB_ASSERT_NEXT(a_command_then_region, clock, reset,
      rsp_valid && !rsp_stall && (rsp_item_kind == sdb_pkg::KIND_COMMAND),
      !rsp_valid || (rsp_item_kind == sdb_pkg::KIND_REGION))

endmodule
`default_nettype wire

@@ test/tb.sv @@
`default_nettype none
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sdb_pkg::*;

   localparam int unsigned IDLE_LIMIT     = 4000;
   localparam int unsigned HOLD_OFF       = 400;
   localparam int unsigned RANDOM_ITEMS   = 410;
   localparam int unsigned CALM_TAIL      = 60;
   localparam int unsigned DRAIN_CYCLES   = 24;
   localparam int unsigned MAX_SECTORS    = MAX_ENTRIES * SECTORS_PER_ENTRY;
   localparam int unsigned SECTOR_BYTES   = 512;

   typedef struct packed {
      logic        opcode;
      logic [47:0] lba;
      logic [15:0] count;
      logic [63:0] addr;
      logic [31:0] busy;
   } sata_request_t;

   typedef struct packed {
      kind_type             kind;
      error_type            err;
      logic [SLOT_W-1:0]    slot;
      logic                 write_dir;
      logic [ENTRY_W-1:0]   entries;
      logic [7:0]           ata;
      logic [47:0]          lba;
      logic [15:0]          sectors;
      logic [63:0]          addr;
      logic [BYTES_W-1:0]   bytes_m1;
      logic                 irq;
      logic                 last;
   } descriptor_beat_t;

   class descriptor_scoreboard;
      descriptor_beat_t expected_beats[$];
      int unsigned      mismatches;

      function new();
         mismatches = 0;
      endfunction

      task report_mismatch(string msg);
         $display("mismatch at %0t: %s", $realtime, msg);
         mismatches++;
      endtask

      function void note_request(sata_request_t r);
         descriptor_beat_t b;
         int               free_slot;
         int unsigned      n_regions;
         int unsigned      secs;
         int unsigned      left;
         logic [63:0]      addr;
         int               i;
         free_slot = -1;
         for (i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (!r.busy[i]) free_slot = i;
         end
         b = '0;
         if (free_slot < 0) begin
            b.kind = KIND_ERROR;
            b.err  = ERR_NO_SLOT;
            b.last = 1'b1;
            expected_beats.push_back(b);
            return;
         end
         if (r.count == 0 || r.count > MAX_SECTORS) begin
            b.kind = KIND_ERROR;
            b.err  = ERR_BAD_COUNT;
            b.last = 1'b1;
            expected_beats.push_back(b);
            return;
         end
         n_regions = (r.count + SECTORS_PER_ENTRY - 1) / SECTORS_PER_ENTRY;
         b.kind      = KIND_COMMAND;
         b.err       = ERR_NONE;
         b.slot      = SLOT_W'(free_slot);
         b.write_dir = r.opcode;
         b.entries   = ENTRY_W'(n_regions);
         b.ata       = r.opcode ? ATA_WRITE_DMA_EXT : ATA_READ_DMA_EXT;
         b.lba       = r.lba;
         b.sectors   = r.count;
         expected_beats.push_back(b);
         addr = r.addr;
         left = r.count;
         for (i = 0; i < int'(n_regions); i++) begin
            secs = (i == int'(n_regions) - 1) ? left : SECTORS_PER_ENTRY;
            b = '0;
            b.kind      = KIND_REGION;
            b.err       = ERR_NONE;
            b.write_dir = r.opcode;
            b.addr      = addr;
            b.bytes_m1  = BYTES_W'(secs * SECTOR_BYTES - 1);
            b.irq       = r.opcode;
            b.last      = (i == int'(n_regions) - 1);
            expected_beats.push_back(b);
            addr = addr + 64'(SECTORS_PER_ENTRY * SECTOR_BYTES);
            left = left - secs;
         end
      endfunction

      task compare_field(string name, logic [63:0] got, logic [63:0] want);
         if (got !== want)
            report_mismatch($sformatf("%s got %0h want %0h", name, got, want));
      endtask

      task check_beat(descriptor_beat_t got);
         descriptor_beat_t want;
         if (expected_beats.size() == 0) begin
            report_mismatch($sformatf("result beat with nothing pending, kind %0d", got.kind));
            return;
         end
         want = expected_beats.pop_front();
         compare_field("item_kind", got.kind, want.kind);
         compare_field("error_code", got.err, want.err);
         compare_field("slot", got.slot, want.slot);
         compare_field("write_dir", got.write_dir, want.write_dir);
         compare_field("entry_count", got.entries, want.entries);
         compare_field("ata_command", got.ata, want.ata);
         compare_field("cmd_lba", got.lba, want.lba);
         compare_field("cmd_sectors", got.sectors, want.sectors);
         compare_field("region_address", got.addr, want.addr);
         compare_field("region_bytes_m1", got.bytes_m1, want.bytes_m1);
         compare_field("irq_on_done", got.irq, want.irq);
         compare_field("last", got.last, want.last);
      endtask
   endclass

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic                 req_opcode = 1'b0;
   logic [47:0]          req_lba = '0;
   logic [15:0]          req_sector_count = '0;
   logic [63:0]          req_buffer_address = '0;
   logic [31:0]          req_busy_slots = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [1:0]           rsp_item_kind;
   logic [1:0]           rsp_error_code;
   logic [SLOT_W-1:0]    rsp_slot;
   logic                 rsp_write_dir;
   logic [ENTRY_W-1:0]   rsp_entry_count;
   logic [7:0]           rsp_ata_command;
   logic [47:0]          rsp_cmd_lba;
   logic [15:0]          rsp_cmd_sectors;
   logic [63:0]          rsp_region_address;
   logic [BYTES_W-1:0]   rsp_region_bytes_m1;
   logic                 rsp_irq_on_done;
   logic                 rsp_last;

   descriptor_scoreboard sb;
   descriptor_beat_t     seen_beat;
   bit                   bursty = 1'b0;
   int unsigned          hold_request = 0;
   int unsigned          hold_left = 0;
   int unsigned          stall_left = 0;
   int unsigned          idle_cycles = 0;

   sata_command_descriptor_builder_core dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_opcode          (req_opcode),
      .req_lba             (req_lba),
      .req_sector_count    (req_sector_count),
      .req_buffer_address  (req_buffer_address),
      .req_busy_slots      (req_busy_slots),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_item_kind       (rsp_item_kind),
      .rsp_error_code      (rsp_error_code),
      .rsp_slot            (rsp_slot),
      .rsp_write_dir       (rsp_write_dir),
      .rsp_entry_count     (rsp_entry_count),
      .rsp_ata_command     (rsp_ata_command),
      .rsp_cmd_lba         (rsp_cmd_lba),
      .rsp_cmd_sectors     (rsp_cmd_sectors),
      .rsp_region_address  (rsp_region_address),
      .rsp_region_bytes_m1 (rsp_region_bytes_m1),
      .rsp_irq_on_done     (rsp_irq_on_done),
      .rsp_last            (rsp_last)
   );

   always #6 clock = ~clock;

   function automatic sata_request_t make_request(logic op, logic [47:0] lba, logic [15:0] count,
                                                  logic [63:0] addr, logic [31:0] busy);
      sata_request_t r;
      r.opcode = op;
      r.lba    = lba;
      r.count  = count;
      r.addr   = addr;
      r.busy   = busy;
      return r;
   endfunction

   function automatic sata_request_t random_request();
      sata_request_t r;
      int unsigned   k;
      int unsigned   pick;
      r.opcode        = 1'($urandom_range(0, 1));
      r.lba[47:32]    = 16'($urandom);
      r.lba[31:0]     = $urandom;
      r.addr[63:32]   = $urandom;
      r.addr[31:0]    = $urandom;
      k = $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 31);
      r.busy    = $urandom | ((32'h1 << k) - 32'h1);
      r.busy[k] = 1'b0;
      r.count = $urandom_range(0, 2) == 0 ? 16'($urandom_range(1, 16))
                                          : 16'($urandom_range(1, MAX_SECTORS));
      pick = $urandom_range(0, 19);
      if (pick == 0) begin
         r.busy  = '1;
         r.count = 16'($urandom);
      end else if (pick == 1) begin
         r.count = '0;
      end else if (pick == 2) begin
         r.count = 16'($urandom_range(MAX_SECTORS + 1, 65535));
      end
      return r;
   endfunction

   task automatic send_request(sata_request_t r);
      req_valid          <= 1'b1;
      req_opcode         <= r.opcode;
      req_lba            <= r.lba;
      req_sector_count   <= r.count;
      req_buffer_address <= r.addr;
      req_busy_slots     <= r.busy;
      do @(posedge clock); while (req_stall !== 1'b0);
      sb.note_request(r);
   endtask

   task automatic idle_sender(int unsigned cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (sb.expected_beats.size() != 0) @(posedge clock);
   endtask

   // receive side: check beats, stall in bursts or one long hold-off
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
            seen_beat.kind      = kind_type'(rsp_item_kind);
            seen_beat.err       = error_type'(rsp_error_code);
            seen_beat.slot      = rsp_slot;
            seen_beat.write_dir = rsp_write_dir;
            seen_beat.entries   = rsp_entry_count;
            seen_beat.ata       = rsp_ata_command;
            seen_beat.lba       = rsp_cmd_lba;
            seen_beat.sectors   = rsp_cmd_sectors;
            seen_beat.addr      = rsp_region_address;
            seen_beat.bytes_m1  = rsp_region_bytes_m1;
            seen_beat.irq       = rsp_irq_on_done;
            seen_beat.last      = rsp_last;
            sb.check_beat(seen_beat);
         end
         if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left != 0)
            hold_left--;
         else if (stall_left != 0)
            stall_left--;
         else if (bursty && $urandom_range(0, 4) == 0)
            stall_left = $urandom_range(1, 17);
         rsp_stall <= (hold_left != 0 || stall_left != 0);
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if ((req_valid === 1'b1 && req_stall === 1'b0) ||
             (rsp_valid === 1'b1 && rsp_stall === 1'b0))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   initial begin
      int unsigned i;
      sb = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_request(make_request(1'b0, '0, 16'd1, '0, '0));
      send_request(make_request(1'b1, '1, 16'(MAX_SECTORS), '1, 32'h7FFF_FFFF));
      send_request(make_request(1'b0, 48'h8000_0000_0000, 16'd0, 64'h1000, '0));
      send_request(make_request(1'b1, 48'd1, 16'(MAX_SECTORS + 1), '0, '0));
      send_request(make_request(1'b0, '0, 16'hFFFF, '1, 32'h0000_0001));
      send_request(make_request(1'b1, '0, 16'd16, '0, '1));
      send_request(make_request(1'b0, '0, 16'd0, '0, '1));
      send_request(make_request(1'b1, 48'h1234_5678_9ABC, 16'd17,
                                64'hFFFF_FFFF_FFFF_E000, 32'h5555_5555));
      send_request(make_request(1'b0, 48'd5, 16'd15, 64'h8000_0000_0000_0000, 32'hFFFF_FFFE));
      send_request(make_request(1'b1, 48'd7, 16'd127, 64'hFFFF_FFFF_FFFF_F000, 32'h0000_FFFF));
      send_request(make_request(1'b0, 48'h7FFF_FFFF_FFFF, 16'd112,
                                64'h0123_4567_89AB_CDEF, 32'hBFFF_FFFF));
      send_request(make_request(1'b1, 48'd9, 16'd33, 64'h200, 32'hFFFF_FF7F));
      send_request(make_request(1'b0, '0, 16'd64, 64'hAAAA_AAAA_AAAA_AAAA, 32'h0000_0002));
      send_request(make_request(1'b1, 48'h5555_5555_5555, 16'd1, '1, '0));
      send_request(make_request(1'b0, 48'hAAAA_AAAA_AAAA, 16'd128,
                                64'h5555_5555_5555_5555, 32'h8000_0000));
      drain_results();

      for (i = 0; i < RANDOM_ITEMS; i++) begin
         if (i % 40 == 0)
            bursty = ($urandom_range(0, 3) != 0);
         if (i >= RANDOM_ITEMS - CALM_TAIL)
            bursty = 1'b0;
         if (i == 100)
            hold_request = HOLD_OFF;
         if (i == 220)
            drain_results();
         send_request(random_request());
         if (bursty && hold_left == 0 && hold_request == 0 && $urandom_range(0, 3) == 0)
            idle_sender($urandom_range(1, 17));
      end

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.mismatches == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
`default_nettype wire
